// ----- design/kmm_pkg.sv -----
// kmm_pkg: types and constants shared by the k-way merge block
// holds the item structs, the head-cell entry and control structs, and the apb register map
// no dependencies
package kmm_pkg;

    localparam int LANE_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int KIND_W    = 2;
    localparam int CFG_W     = 4;
    localparam int MAX_LANES = 8;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register index taken from paddr[2]
    localparam logic REG_ACTIVE_LANES = 1'b0;
    localparam logic [CFG_W-1:0] ACTIVE_LANES_RESET = 4'd2;

    localparam logic [KIND_W-1:0] KIND_ELEMENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic [LANE_W-1:0]         lane;
        logic signed [VALUE_W-1:0] value;
        logic                      exhausted;
    } feed_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [LANE_W-1:0]         source_lane;
        logic [KIND_W-1:0]         kind;
    } merged_t;

    // one held head, kept in ascending (value, lane) order along the chain
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [LANE_W-1:0]         lane;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                      ins;
        logic                      pop;
        logic                      clr;
        logic [CFG_W-1:0]          n_eff;
        logic signed [VALUE_W-1:0] new_value;
        logic [LANE_W-1:0]         new_lane;
    } cell_ctl_t;

endpackage

// ----- design/k_way_merge_min_select.sv -----
// k_way_merge_min_select: top level of the k-way merge block
// holds lane status, the cell chain, the apb register and a two-item result queue
// depends on kmm_pkg and kmm_cell
//
// Merges up to eight ascending streams of signed 32-bit values. Each feed item loads one
// lane's head or marks that lane exhausted; once every active lane holds a head or is
// exhausted, the smallest head (lowest lane on ties) is emitted and that lane must be fed
// again. When all active lanes are exhausted and empty a done item is emitted and all lanes
// clear. Feeding an inactive, full or exhausted lane returns an error item. The block takes
// one feed item per clock while the result queue is not full; each result shows on merged the
// cycle after its feed item is accepted, or later while earlier results still wait in the
// queue. The heads sit in a chain of LANES cells kept in sorted order, so an insert and a
// removal of the minimum both finish in the cycle of the item. A two-item result queue lets
// feeding continue for one item while a result waits. active_lanes sits at byte address 0.
module k_way_merge_min_select #(
    parameter int LANES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmm_pkg::ADDR_W-1:0]    paddr,
    input  logic [kmm_pkg::DATA_W-1:0]    pwdata,
    output logic [kmm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          feed_valid,
    output logic                          feed_ready,
    input  kmm_pkg::feed_t                feed,
    output logic                          merged_valid,
    input  logic                          merged_ready,
    output kmm_pkg::merged_t              merged
);
    import kmm_pkg::*;

    localparam logic [CFG_W-1:0] LANE_LIMIT = CFG_W'(LANES > MAX_LANES ? MAX_LANES : LANES);

    logic [CFG_W-1:0]     active_lanes_reg;
    logic [CFG_W-1:0]     n_eff;
    logic [MAX_LANES-1:0] full_reg;
    logic [MAX_LANES-1:0] full_upd;
    logic [MAX_LANES-1:0] full_next;
    logic [MAX_LANES-1:0] fin_reg;
    logic [MAX_LANES-1:0] fin_next;

    logic acc;
    logic err;
    logic all_ready;
    logic any_act;
    logic do_pop;
    logic do_clr;
    logic res_valid;
    merged_t res;

    cell_ctl_t  ctl;
    entry_t     held_a [LANES];
    entry_t     post_a [LANES];
    logic [LANES-1:0] gt_v;
    logic [LANES-1:0] rem_v;
    logic [LANES-1:0] first_v;

    logic signed [VALUE_W-1:0] emit_value;
    logic [LANE_W-1:0]         emit_lane;

    merged_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       q_pop;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_LANES) ?
                    {{(DATA_W-CFG_W){1'b0}}, active_lanes_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_lanes_reg <= ACTIVE_LANES_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_LANES)
            active_lanes_reg <= pwdata[CFG_W-1:0];
    end

    always_comb
    begin
        if (active_lanes_reg == '0)
            n_eff = CFG_W'(1);
        else if (active_lanes_reg > LANE_LIMIT)
            n_eff = LANE_LIMIT;
        else
            n_eff = active_lanes_reg;
    end

    assign acc = feed_valid & feed_ready;
    assign err = ({1'b0, feed.lane} >= n_eff) || full_reg[feed.lane] || fin_reg[feed.lane];

    always_comb
    begin
        full_upd = full_reg;
        fin_next = fin_reg;
        if (acc && !err)
        begin
            if (feed.exhausted)
                fin_next[feed.lane] = 1'b1;
            else
                full_upd[feed.lane] = 1'b1;
        end
        all_ready = 1'b1;
        for (int i = 0; i < MAX_LANES; i++)
        begin
            if ((CFG_W'(i) < n_eff) && !(full_upd[i] || fin_next[i]))
                all_ready = 1'b0;
        end
    end

    assign any_act = rem_v[LANES-1];
    assign do_pop  = acc & ~err & all_ready & any_act;
    assign do_clr  = acc & ~err & all_ready & ~any_act;

    assign ctl.ins       = acc & ~err & ~feed.exhausted;
    assign ctl.pop       = do_pop;
    assign ctl.clr       = do_clr;
    assign ctl.n_eff     = n_eff;
    assign ctl.new_value = feed.value;
    assign ctl.new_lane  = feed.lane;

    for (genvar g = 0; g < LANES; g++)
    begin : g_cell
        entry_t pe;
        entry_t np;
        logic   pg;
        logic   pr;
        if (g == 0)
        begin : g_head
            assign pe = '0;
            assign pg = 1'b0;
            assign pr = 1'b0;
        end
        else
        begin : g_mid
            assign pe = held_a[g-1];
            assign pg = gt_v[g-1];
            assign pr = rem_v[g-1];
        end
        if (g == LANES - 1)
        begin : g_tail
            assign np = '0;
        end
        else
        begin : g_link
            assign np = post_a[g+1];
        end

        kmm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_entry (pe),
            .prev_gt    (pg),
            .prev_rem   (pr),
            .next_post  (np),
            .held       (held_a[g]),
            .gt         (gt_v[g]),
            .post       (post_a[g]),
            .rem        (rem_v[g]),
            .first      (first_v[g])
        );
    end

    // one-hot pick of the first active head
    always_comb
    begin
        emit_value = '0;
        emit_lane  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (first_v[i])
            begin
                emit_value = emit_value | post_a[i].value;
                emit_lane  = emit_lane | post_a[i].lane;
            end
        end
    end

    always_comb
    begin
        full_next = full_upd;
        if (do_pop)
            full_next[emit_lane] = 1'b0;
        if (do_clr)
            full_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
            fin_reg  <= '0;
        end
        else if (do_clr)
        begin
            full_reg <= '0;
            fin_reg  <= '0;
        end
        else
        begin
            full_reg <= full_next;
            fin_reg  <= fin_next;
        end
    end

    assign res_valid = acc & (err | all_ready);

    always_comb
    begin
        if (err)
        begin
            res.merged_value = '0;
            res.source_lane  = feed.lane;
            res.kind         = KIND_ERROR;
        end
        else if (any_act)
        begin
            res.merged_value = emit_value;
            res.source_lane  = emit_lane;
            res.kind         = KIND_ELEMENT;
        end
        else
        begin
            res.merged_value = '0;
            res.source_lane  = '0;
            res.kind         = KIND_DONE;
        end
    end

    // two-item result queue
    assign merged_valid = (count_reg != 2'd0);
    assign feed_ready   = (count_reg != 2'd2);
    assign merged       = slot_reg[rd_ptr_reg];
    assign q_pop        = merged_valid & merged_ready;

    always_ff @(posedge clk)
    begin
        if (res_valid)
            slot_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res_valid)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, res_valid} - {1'b0, q_pop};
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue over capacity");

    a_pop_from_full: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> (full_reg[emit_lane] || (ctl.ins && feed.lane == emit_lane)))
        else $error("emitted head from a lane that holds none");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        do_clr |=> (full_reg == '0 && fin_reg == '0 && held_a[0].valid == 1'b0))
        else $error("done item did not clear the lanes");

    a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && err) |=> ($stable(full_reg) && $stable(fin_reg)))
        else $error("error item changed lane state");

endmodule

// ----- design/kmm_cell.sv -----
// kmm_cell: one slot of the sorted head chain
// inserts a new head by comparing against its own entry, pops by shifting from its right neighbor
// depends on kmm_pkg
module kmm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  kmm_pkg::cell_ctl_t ctl,
    input  kmm_pkg::entry_t    prev_entry,
    input  logic               prev_gt,
    input  logic               prev_rem,
    input  kmm_pkg::entry_t    next_post,
    output kmm_pkg::entry_t    held,
    output logic               gt,
    output kmm_pkg::entry_t    post,
    output logic               rem,
    output logic               first
);
    import kmm_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    entry_t new_e;
    logic   act;

    always_comb
    begin
        new_e.valid = 1'b1;
        new_e.value = ctl.new_value;
        new_e.lane  = ctl.new_lane;

        // empty slots count as larger than anything; sign flip gives a signed order
        gt = !entry_reg.valid ||
             ({~entry_reg.value[VALUE_W-1], entry_reg.value[VALUE_W-2:0], entry_reg.lane} >
              {~ctl.new_value[VALUE_W-1], ctl.new_value[VALUE_W-2:0], ctl.new_lane});

        if (ctl.ins)
        begin
            if (prev_gt)
                post = prev_entry;
            else if (gt)
                post = new_e;
            else
                post = entry_reg;
        end
        else
        begin
            post = entry_reg;
        end

        // only heads of lanes in the active count can be picked
        act   = post.valid && ({1'b0, post.lane} < ctl.n_eff);
        rem   = prev_rem | act;
        first = act & ~prev_rem;

        if (ctl.clr)
            entry_next = '0;
        else if (ctl.pop && rem)
            entry_next = next_post;
        else
            entry_next = post;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign held = entry_reg;

endmodule
